// File: hw/rtl/bmhq_pkg.sv
// Shared constants and controller/datapath interface types of the min-heap queue.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    // Payload widths
    localparam int CMD_W = 2;
    localparam int IDX_W = 16;
    localparam int KEY_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W = 11;
    localparam int ENTRY_W = IDX_W + KEY_W;

    // Default number of heap entries
    localparam int DEF_CAPACITY = 1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic              start_push;   // append input entry, count up
        logic              start_pop;    // read root and last entry, count down
        logic              clear_cnt;    // empty the heap
        logic              zero_pop;     // clear popped fields
        logic              rd_parent;    // read parent of current position
        logic              rd_children;  // read both children of current position
        logic              pop_load;     // capture root as popped, last as moving entry
        logic              wr_cur;       // store moving entry at current position
        logic              wr_parent;    // move parent down, climb one level
        logic              wr_child;     // move chosen child up, descend one level
        logic              res_load;     // load result into output register
        logic [STAT_W-1:0] res_status;   // status of the result beat
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;       // count at capacity
        logic empty;      // count zero
        logic at_root;    // current position is the root
        logic has_left;   // left child lies inside the heap
        logic up_less;    // moving entry strictly below its parent
        logic down_move;  // a child strictly below the moving entry
    } dp_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmhq_ctrl.sv
// Controller state machine of the min-heap queue: sequences push, pop and clear.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [bmhq_pkg::CMD_W-1:0]  command,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output bmhq_pkg::dp_cmd_t                cmd,
    input  wire bmhq_pkg::dp_sts_t           sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_CHK,
        ST_PUSH_CMP,
        ST_POP_LOAD,
        ST_DOWN_CHK,
        ST_DOWN_CMP,
        ST_RESULT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [bmhq_pkg::STAT_W-1:0]     status_reg;
    logic [bmhq_pkg::STAT_W-1:0]     status_next;
    logic                            accept;

    assign accept = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd = '0;
        cmd.res_status = status_reg;
        state_next = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.zero_pop = 1'b1;
                    status_next = bmhq_pkg::STAT_DONE;
                    state_next = ST_RESULT;
                    priority if (command == bmhq_pkg::CMD_PUSH)
                    begin
                        if (sts.full)
                        begin
                            status_next = bmhq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.start_push = 1'b1;
                            state_next = ST_PUSH_CHK;
                        end
                    end
                    else if (command == bmhq_pkg::CMD_POP)
                    begin
                        if (sts.empty)
                        begin
                            status_next = bmhq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.start_pop = 1'b1;
                            state_next = ST_POP_LOAD;
                        end
                    end
                    else if (command == bmhq_pkg::CMD_CLEAR)
                    begin
                        cmd.clear_cnt = 1'b1;
                    end
                    else
                    begin
                        // unused code: report count only
                    end
                end
            end
            ST_PUSH_CHK:
            begin
                if (sts.at_root)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next = ST_PUSH_CMP;
                end
            end
            ST_PUSH_CMP:
            begin
                if (sts.up_less)
                begin
                    cmd.wr_parent = 1'b1;
                    state_next = ST_PUSH_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next = ST_DOWN_CHK;
            end
            ST_DOWN_CHK:
            begin
                if (sts.has_left)
                begin
                    cmd.rd_children = 1'b1;
                    state_next = ST_DOWN_CMP;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_DOWN_CMP:
            begin
                if (sts.down_move)
                begin
                    cmd.wr_child = 1'b1;
                    state_next = ST_DOWN_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Load the result once the output register is free or drains
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.res_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            status_reg <= bmhq_pkg::STAT_DONE;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg <= status_next;
        end
    end

    // One item at a time: an accepted beat stalls the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in work");

    // A pop on an empty heap goes straight to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == bmhq_pkg::CMD_POP) && sts.empty) |=> (state_reg == ST_RESULT))
        else $error("pop on empty heap started a sift");

    // A stalled result beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result beat dropped while stalled");

endmodule

`default_nettype wire

// File: hw/rtl/bmhq_dpath.sv
// Datapath of the min-heap queue: heap memory, position and count registers, key compares.
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dpath
#(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bmhq_pkg::dp_cmd_t                  cmd,
    output bmhq_pkg::dp_sts_t                       sts,
    input  wire logic [bmhq_pkg::IDX_W-1:0]         item_index,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]  key_value,
    output logic [bmhq_pkg::STAT_W-1:0]             status,
    output logic [bmhq_pkg::IDX_W-1:0]              popped_index,
    output logic signed [bmhq_pkg::KEY_W-1:0]       popped_key,
    output logic [bmhq_pkg::CNT_W-1:0]              entry_count
);

    localparam int PW = $clog2(CAPACITY + 1);   // position and count width
    localparam int PX = PW + 1;                 // room for child positions
    localparam int AW = $clog2(CAPACITY);       // memory address width
    localparam int EW = bmhq_pkg::ENTRY_W;
    localparam int KW = bmhq_pkg::KEY_W;
    localparam int IW = bmhq_pkg::IDX_W;

    // Heap storage, position p lives at address p-1
    logic [EW-1:0]              mem [CAPACITY];

    logic [PW-1:0]              count_reg;
    logic [PW-1:0]              count_next;
    logic [PW-1:0]              pos_reg;
    logic [PW-1:0]              pos_next;
    logic [IW-1:0]              cur_idx_reg;
    logic signed [KW-1:0]       cur_key_reg;
    logic [IW-1:0]              pop_idx_reg;
    logic signed [KW-1:0]       pop_key_reg;
    logic [EW-1:0]              rd_a_reg;
    logic [EW-1:0]              rd_b_reg;
    logic [bmhq_pkg::STAT_W-1:0] out_status_reg;
    logic [IW-1:0]              out_idx_reg;
    logic signed [KW-1:0]       out_key_reg;
    logic [bmhq_pkg::CNT_W-1:0] out_cnt_reg;

    logic [PX-1:0]              pos_ext;
    logic [PX-1:0]              cnt_ext;
    logic [PX-1:0]              left_pos;
    logic [PX-1:0]              right_pos;
    logic [PX-1:0]              parent_adr;
    logic [PX-1:0]              last_adr;
    logic [PX-1:0]              pos_adr;
    logic [PX-1:0]              adr_a_full;
    logic [PX-1:0]              adr_b_full;
    logic [PX-1:0]              child_pos;
    logic [AW-1:0]              adr_a;
    logic [AW-1:0]              adr_b;
    logic [AW-1:0]              wr_adr;
    logic                       rd_en;
    logic                       wr_en;
    logic [EW-1:0]              wr_data;
    logic signed [KW-1:0]       key_a;
    logic signed [KW-1:0]       key_b;
    logic                       right_ok;
    logic                       l_lt_cur;
    logic                       r_lt_cur;
    logic                       r_lt_l;
    logic                       right_lt;

    // Position arithmetic
    assign pos_ext = {1'b0, pos_reg};
    assign cnt_ext = {1'b0, count_reg};
    assign left_pos = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign parent_adr = {2'b00, pos_reg[PW-1:1]} - PX'(1);
    assign last_adr = cnt_ext - PX'(1);
    assign pos_adr = pos_ext - PX'(1);
    assign right_ok = (right_pos <= cnt_ext);

    // Select read addresses
    always_comb
    begin
        adr_a_full = '0;
        adr_b_full = last_adr;
        if (cmd.rd_parent)
        begin
            adr_a_full = parent_adr;
        end
        else if (cmd.rd_children)
        begin
            adr_a_full = left_pos - PX'(1);
            adr_b_full = left_pos;
        end
    end

    assign adr_a = adr_a_full[AW-1:0];
    assign adr_b = adr_b_full[AW-1:0];
    assign wr_adr = pos_adr[AW-1:0];
    assign rd_en = cmd.start_pop || cmd.rd_parent || cmd.rd_children;

    // Compare keys: parent and children against the moving entry
    assign key_a = rd_a_reg[KW-1:0];
    assign key_b = rd_b_reg[KW-1:0];
    assign l_lt_cur = (key_a < cur_key_reg);
    assign r_lt_cur = (key_b < cur_key_reg);
    assign r_lt_l = (key_b < key_a);
    assign right_lt = right_ok && (l_lt_cur ? r_lt_l : r_lt_cur);
    assign child_pos = right_lt ? right_pos : left_pos;

    // Select write data
    assign wr_en = cmd.wr_cur || cmd.wr_parent || cmd.wr_child;
    always_comb
    begin
        priority if (cmd.wr_parent)
        begin
            wr_data = rd_a_reg;
        end
        else if (cmd.wr_child)
        begin
            wr_data = right_lt ? rd_b_reg : rd_a_reg;
        end
        else
        begin
            wr_data = {cur_idx_reg, cur_key_reg};
        end
    end

    // Status toward the controller
    assign sts.full = (count_reg == PW'(CAPACITY));
    assign sts.empty = (count_reg == '0);
    assign sts.at_root = (pos_reg == PW'(1));
    assign sts.has_left = (left_pos <= cnt_ext);
    assign sts.up_less = (cur_key_reg < key_a);
    assign sts.down_move = l_lt_cur || right_lt;

    // Next count and position
    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        priority if (cmd.start_push)
        begin
            count_next = count_reg + PW'(1);
            pos_next = count_reg + PW'(1);
        end
        else if (cmd.start_pop)
        begin
            count_next = count_reg - PW'(1);
            pos_next = PW'(1);
        end
        else if (cmd.clear_cnt)
        begin
            count_next = '0;
        end
        else if (cmd.wr_parent)
        begin
            pos_next = {1'b0, pos_reg[PW-1:1]};
        end
        else if (cmd.wr_child)
        begin
            pos_next = child_pos[PW-1:0];
        end
    end

    // Hold count and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg <= PW'(1);
        end
        else
        begin
            count_reg <= count_next;
            pos_reg <= pos_next;
        end
    end

    // Heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_adr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[adr_a];
            rd_b_reg <= mem[adr_b];
        end
    end

    // Moving entry, popped entry and output beat
    always_ff @(posedge clk)
    begin
        if (cmd.start_push)
        begin
            cur_idx_reg <= item_index;
            cur_key_reg <= key_value;
        end
        else if (cmd.pop_load)
        begin
            cur_idx_reg <= rd_b_reg[EW-1:KW];
            cur_key_reg <= key_b;
        end
        if (cmd.zero_pop)
        begin
            pop_idx_reg <= '0;
            pop_key_reg <= '0;
        end
        else if (cmd.pop_load)
        begin
            pop_idx_reg <= rd_a_reg[EW-1:KW];
            pop_key_reg <= key_a;
        end
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            out_idx_reg <= pop_idx_reg;
            out_key_reg <= pop_key_reg;
            out_cnt_reg <= bmhq_pkg::CNT_W'(count_reg);
        end
    end

    assign status = out_status_reg;
    assign popped_index = out_idx_reg;
    assign popped_key = out_key_reg;
    assign entry_count = out_cnt_reg;

    // Count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PW'(CAPACITY))
        else $error("entry count above capacity");

    // A sift-up step never climbs from the root
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_parent |-> (pos_reg > PW'(1)))
        else $error("parent move issued at the root");

    // A sift-down step always goes deeper and stays inside the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_child |=> ((pos_reg > $past(pos_reg)) && (pos_reg <= count_reg)))
        else $error("child move left the heap or did not descend");

endmodule

`default_nettype wire

// File: hw/rtl/binary_min_heap_queue_unit.sv
// Top level of the binary min-heap priority queue: controller plus datapath.
//
// Priority queue of (index, signed Q16.16 key) entries kept as a binary min-heap
// in a single CAPACITY x 48-bit memory with one write and two registered read
// ports. One command is in work at a time. A push places the new entry last
// and sifts it up, each level a parent read followed by a compare that either
// moves the parent down or writes the entry; a pop loads the root as result and
// the last entry as moving entry, then sifts it down, each level a read of both
// children followed by a compare that either moves the smaller child up or
// writes the entry. Once the result is loaded, the result beat is valid in the
// cycle after, and the next command can be accepted in that same cycle. At the
// default capacity of 1024 the longest command is a push climbing ten levels.
// Clear, a push on a full heap, a pop on an empty heap and the unused code skip
// the sift. A result that cannot leave because the previous beat is still
// stalled in the output register holds the unit until that beat is taken.
// Equal keys never swap. The result beat sits in an output register, so the
// next command is accepted while it waits. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_unit
#(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bmhq_pkg::CMD_W-1:0]         command,
    input  wire logic [bmhq_pkg::IDX_W-1:0]         item_index,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]  key_value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bmhq_pkg::STAT_W-1:0]             status,
    output logic [bmhq_pkg::IDX_W-1:0]              popped_index,
    output logic signed [bmhq_pkg::KEY_W-1:0]       popped_key,
    output logic [bmhq_pkg::CNT_W-1:0]              entry_count
);

    bmhq_pkg::dp_cmd_t dp_cmd;
    bmhq_pkg::dp_sts_t dp_sts;

    // Sequence each command
    bmhq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    // Store entries and compare keys
    bmhq_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .item_index   (item_index),
        .key_value    (key_value),
        .status       (status),
        .popped_index (popped_index),
        .popped_key   (popped_key),
        .entry_count  (entry_count)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the binary min-heap priority queue unit.
`timescale 1ns / 1ps

module tb;

    localparam int CMD_W = bmhq_pkg::CMD_W;
    localparam int IDX_W = bmhq_pkg::IDX_W;
    localparam int KEY_W = bmhq_pkg::KEY_W;
    localparam int STAT_W = bmhq_pkg::STAT_W;
    localparam int CNT_W = bmhq_pkg::CNT_W;
    localparam logic [CMD_W-1:0] CMD_PUSH = bmhq_pkg::CMD_PUSH;
    localparam logic [CMD_W-1:0] CMD_POP = bmhq_pkg::CMD_POP;
    localparam logic [CMD_W-1:0] CMD_CLEAR = bmhq_pkg::CMD_CLEAR;
    localparam logic [STAT_W-1:0] STAT_DONE = bmhq_pkg::STAT_DONE;
    localparam logic [STAT_W-1:0] STAT_EMPTY = bmhq_pkg::STAT_EMPTY;
    localparam logic [STAT_W-1:0] STAT_FULL = bmhq_pkg::STAT_FULL;

    localparam int CAPACITY = bmhq_pkg::DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MINUS_ONE = -32'sd1;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
    } heap_entry_t;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic [IDX_W-1:0]        idx;
        logic signed [KEY_W-1:0] key;
        logic [CNT_W-1:0]        count;
    } heap_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        command = CMD_PUSH;
    logic [IDX_W-1:0]        item_index = '0;
    logic signed [KEY_W-1:0] key_value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        popped_index;
    logic signed [KEY_W-1:0] popped_key;
    logic [CNT_W-1:0]        entry_count;

    // Shadow heap and the queue of results it predicts
    heap_entry_t  shadow_heap [1:CAPACITY];
    int unsigned  shadow_count = 0;
    heap_result_t pending_results [$];

    int unsigned mismatch_count = 0;
    bit          no_gaps = 1'b0;
    int          stall_left = 0;
    int unsigned stall_roll;

    binary_min_heap_queue_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .item_index(item_index),
        .key_value(key_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .popped_index(popped_index),
        .popped_key(popped_key),
        .entry_count(entry_count)
    );

    always #2 clk = ~clk;

    // Shadow heap maintenance
    function automatic void swap_shadow(input int unsigned a, input int unsigned b);
        heap_entry_t t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void sift_shadow_up(input int unsigned start);
        int unsigned pos;
        int unsigned up;
        pos = start;
        while (pos > 1) begin
            up = pos / 2;
            if (shadow_heap[pos].key < shadow_heap[up].key)
                swap_shadow(pos, up);
            pos = up;
        end
    endfunction

    function automatic void sift_shadow_down(input int unsigned n);
        int unsigned pos;
        int unsigned here;
        int unsigned left;
        int unsigned right;
        pos = 1;
        while (pos < n) begin
            here = pos;
            left = pos * 2;
            right = left + 1;
            if (left <= n && shadow_heap[left].key < shadow_heap[pos].key)
                pos = left;
            if (right <= n && shadow_heap[right].key < shadow_heap[pos].key)
                pos = right;
            if (pos == here)
                break;
            swap_shadow(here, pos);
        end
    endfunction

    // Apply one command to the shadow heap and queue the result it must give
    function automatic void predict_heap_result(input logic [CMD_W-1:0] cmd,
                                                input logic [IDX_W-1:0] idx,
                                                input logic signed [KEY_W-1:0] key);
        heap_result_t r;
        r.status = STAT_DONE;
        r.idx = '0;
        r.key = '0;
        if (cmd == CMD_PUSH) begin
            if (shadow_count >= CAPACITY) begin
                r.status = STAT_FULL;
            end
            else begin
                shadow_count++;
                shadow_heap[shadow_count].idx = idx;
                shadow_heap[shadow_count].key = key;
                sift_shadow_up(shadow_count);
            end
        end
        else if (cmd == CMD_POP) begin
            if (shadow_count == 0) begin
                r.status = STAT_EMPTY;
            end
            else begin
                r.idx = shadow_heap[1].idx;
                r.key = shadow_heap[1].key;
                shadow_heap[1] = shadow_heap[shadow_count];
                shadow_count--;
                sift_shadow_down(shadow_count);
            end
        end
        else if (cmd == CMD_CLEAR) begin
            shadow_count = 0;
        end
        r.count = shadow_count[CNT_W-1:0];
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Sender gap: mostly short, a few long, none in a gap-free stretch
    function automatic int pick_gap();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 50);
    endfunction

    // Keys: full range, a few repeating values for ties, and the extremes
    function automatic logic signed [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom;
        if (roll < 90)
            return ($signed(32'($urandom_range(0, 7))) - 32'sd4) <<< 16;
        case ($urandom_range(0, 3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MINUS_ONE;
            default: return '0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: result %s mismatch, got %0h, expected %0h",
                 $time, what, got, want);
    endtask

    // Send one beat and predict its result once accepted
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [IDX_W-1:0] idx,
                                input logic signed [KEY_W-1:0] key);
        int gap;
        command <= cmd;
        item_index <= idx;
        key_value <= key;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_heap_result(cmd, idx, key);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_push();
        send_command(CMD_PUSH, 16'($urandom), pick_key());
    endtask

    task automatic send_pop();
        send_command(CMD_POP, 16'($urandom), $urandom);
    endtask

    // Extremes of every field, each command, ties, empty pop, clear and the unused code
    task automatic run_directed_cases();
        send_pop();
        send_command(CMD_PUSH, 16'hFFFF, KEY_MAX);
        send_command(CMD_PUSH, 16'h0000, KEY_MIN);
        send_command(CMD_PUSH, 16'h1234, KEY_MINUS_ONE);
        send_command(CMD_PUSH, 16'h0001, 32'sd0);
        send_command(CMD_PUSH, 16'h0002, 32'sd0);
        send_command(CMD_PUSH, 16'h0003, 32'sd0);
        send_command(CMD_PUSH, 16'h5555, 32'sh0001_0000);
        send_command(CMD_PUSH, 16'hAAAA, 32'shFFFF_0000);
        repeat (9) send_pop();
        send_command(CMD_UNUSED, 16'hFFFF, KEY_MINUS_ONE);
        send_command(CMD_PUSH, 16'h00FF, KEY_MAX);
        send_command(CMD_PUSH, 16'hFF00, KEY_MAX);
        send_command(CMD_CLEAR, 16'hFFFF, KEY_MINUS_ONE);
        send_pop();
        send_command(CMD_UNUSED, 16'h0000, 32'sd0);
    endtask

    // Fill to capacity, push into a full heap, pop from a deep heap, then clear
    task automatic run_capacity_limit();
        no_gaps = 1'b1;
        repeat (CAPACITY) send_random_push();
        no_gaps = 1'b0;
        send_command(CMD_PUSH, 16'hFFFF, KEY_MIN);
        send_command(CMD_PUSH, 16'h0000, KEY_MAX);
        repeat (12) send_pop();
        repeat (12) send_random_push();
        send_command(CMD_PUSH, 16'h7777, KEY_MINUS_ONE);
        repeat (4) send_pop();
        send_command(CMD_CLEAR, 16'($urandom), $urandom);
    endtask

    // Push bursts followed by pop bursts with random content, plus noise
    task automatic run_random_traffic();
        int unsigned sent;
        int unsigned roll;
        int unsigned pushes;
        int unsigned pops;
        logic [CMD_W-1:0] cmd;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 15)
                no_gaps = ~no_gaps;
            roll = $urandom_range(0, 99);
            if (roll < 82) begin
                pushes = $urandom_range(1, 40);
                if (shadow_count + pushes > CAPACITY)
                    pushes = CAPACITY - shadow_count;
                repeat (pushes) send_random_push();
                if ($urandom_range(0, 99) < 30)
                    pops = shadow_count + $urandom_range(0, 2);
                else
                    pops = $urandom_range(1, pushes + 4);
                repeat (pops) send_pop();
                sent += pushes + pops;
            end
            else if (roll < 94) begin
                repeat ($urandom_range(1, 6)) begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    send_command(cmd, 16'($urandom), $urandom);
                    if (cmd != CMD_UNUSED)
                        sent++;
                end
            end
            else begin
                send_command(CMD_CLEAR, 16'($urandom), $urandom);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver stall: runs of no stall, short stalls and a few long ones
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end
        else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 55) begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(0, 20);
            end
            else if (stall_roll < 96) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    // Check each accepted result beat against the oldest prediction
    always @(posedge clk) begin
        heap_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing predicted", 32'(status), 32'hX);
            end
            else begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (popped_index !== want.idx)
                    report_mismatch("popped_index", 32'(popped_index), 32'(want.idx));
                if (popped_key !== want.key)
                    report_mismatch("popped_key", popped_key, want.key);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
            end
        end
    end

    // Run the tests in turn, then drain and decide
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_cases();
        run_capacity_limit();
        run_random_traffic();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
